@@ rtl/core/pae_pkg.sv @@
// Shared types and constants of the piecewise affine equalizer.
package pae_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 24;
  localparam int SLOPE_W  = 16;
  localparam int COUNT_W  = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_DVD_W = 32;
  localparam int DIV_DVS_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_SAT = {LEVEL_W{1'b1}};

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_POINTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_MIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_MIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_MAX       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN      = 3'd7;

  typedef struct packed {
    logic                command;
    logic [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mapped_value;
    logic                covered;
  } out_t;

  // One segment: start position, start level, slope.
  typedef struct packed {
    logic [SAMPLE_W-1:0] pos;
    logic [LEVEL_W-1:0]  lvl;
    logic [SLOPE_W-1:0]  slope;
  } seg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic                 busy;
    logic [DIV_DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/core/pae_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/pae_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
module pae_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pae_pkg::div_req_t req,
  output pae_pkg::div_rsp_t rsp
);
  import pae_pkg::*;

  localparam int CNT_W = $clog2(DIV_DVD_W + 1);

  logic [DIV_DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_DVS_W:0]   rem_r, rem_nxt;
  logic [DIV_DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DVS_W:0]   rem_sh;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[DIV_DVS_W-1:0], dvd_r[DIV_DVD_W-1]};
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DIV_DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        dvd_nxt = {dvd_r[DIV_DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        dvd_nxt = {dvd_r[DIV_DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.busy     = busy_r;
  assign rsp.quotient = dvd_r;

endmodule

@@ rtl/core/piecewise_affine_equalizer.sv @@
// Load beat: with no knot on it, the beat only checks the knot loop, unless the knot index is
//   fetched again with a divider pass; each knot it places takes up to three divider passes
//   (knot index, target level, in-range slope); the closing knot adds at most a slope pass.
// Map beat: binary search (one segment RAM read a step), then the segment end and result;
//   an empty chain goes straight to the result, which waits while the result register is stalled.
// Reset: synchronous, active low; clears control state, restores register defaults.
module piecewise_affine_equalizer #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  pae_pkg::in_t                         in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output pae_pkg::out_t                        out_data,
  input  logic                                 cfg_wr_en,
  input  logic [pae_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pae_pkg::CFG_W-1:0]            cfg_data
);
  import pae_pkg::*;

  localparam int IW  = $clog2(MAX_SEGMENTS);
  localparam int CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int BW  = (IW > 1) ? $clog2(IW) : 1;
  localparam int SW  = $bits(seg_t);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LCHK  = 5'd1;
  localparam logic [4:0] S_LIDX  = 5'd2;
  localparam logic [4:0] S_LTGT  = 5'd3;
  localparam logic [4:0] S_LEND  = 5'd4;
  localparam logic [4:0] S_ACHK  = 5'd5;
  localparam logic [4:0] S_ADEC  = 5'd6;
  localparam logic [4:0] S_ADIV  = 5'd7;
  localparam logic [4:0] S_AWR   = 5'd8;
  localparam logic [4:0] S_ARET  = 5'd9;
  localparam logic [4:0] S_MRB   = 5'd10;
  localparam logic [4:0] S_MCB   = 5'd11;
  localparam logic [4:0] S_MRJ   = 5'd12;
  localparam logic [4:0] S_MCJ   = 5'd13;
  localparam logic [4:0] S_MCE   = 5'd14;
  localparam logic [4:0] S_MMUL  = 5'd15;
  localparam logic [4:0] S_MADD  = 5'd16;
  localparam logic [4:0] S_MOUT  = 5'd17;

  // Configuration registers.
  logic [COUNT_W-1:0]  pix_cnt_r;
  logic [5:0]          ctl_pts_r;
  logic [SLOPE_W-1:0]  smax_r, smin_r;
  logic [SAMPLE_W-1:0] dmin_r, dmax_r, rmax_r, rmin_r;

  // Engine state.
  logic [4:0]           state_r, state_nxt;
  logic [CW-1:0]        seg_cnt_r, seg_cnt_nxt;
  logic [COUNT_W-1:0]   sidx_r, sidx_nxt;
  logic [6:0]           knot_r, knot_nxt;
  logic [SAMPLE_W-1:0]  last_pos_r, last_pos_nxt;
  logic [LEVEL_W-1:0]   last_lvl_r, last_lvl_nxt;
  logic                 idx_ok_r, idx_ok_nxt;
  logic [COUNT_W-1:0]   idx_r, idx_nxt;
  logic                 final_r, final_nxt;
  logic [SAMPLE_W-1:0]  v_r, v_nxt;
  logic [SAMPLE_W-1:0]  x1_r, x1_nxt;
  logic [LEVEL_W-1:0]   tgt_r, tgt_nxt;
  logic [SAMPLE_W-1:0]  dx_r, dx_nxt;
  logic [31:0]          lo_r, lo_nxt, hi_r, hi_nxt;
  logic [SLOPE_W-1:0]   s_r, s_nxt;
  logic [32:0]          y_r, y_nxt;
  logic [IW-1:0]        base_r, base_nxt;
  logic [BW-1:0]        bit_r, bit_nxt;
  logic                 probe_ok_r, probe_ok_nxt;
  logic [IW-1:0]        probe_r, probe_nxt;
  seg_t                 seg_r, seg_nxt;
  logic [SAMPLE_W-1:0]  end_r, end_nxt;
  logic [31:0]          prod_r, prod_nxt;
  logic                 cov_r, cov_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;

  // RAM and divider links.
  logic                 wr_en;
  logic [IW-1:0]        rd_addr;
  seg_t                 rd_seg;
  logic [SW-1:0]        rd_raw;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  // Working values.
  logic [COUNT_W-1:0]   n_eff;
  logic [6:0]           np1;
  logic [IW-1:0]        probe;
  logic [SAMPLE_W-1:0]  dx_c;
  logic signed [33:0]   diff_s;
  logic [CW:0]          base_p1;
  logic [COUNT_W:0]     sidx_p1;
  logic [32:0]          y_map;
  logic [32:0]          y_hi, y_lo;

  assign n_eff   = (pix_cnt_r == '0) ? COUNT_W'(1) : pix_cnt_r;
  assign np1     = {1'b0, ctl_pts_r} + 7'd1;
  assign probe   = base_r | (IW'(1) << bit_r);
  assign dx_c    = x1_r - last_pos_r;
  assign diff_s  = $signed({10'd0, tgt_r}) - $signed({10'd0, last_lvl_r});
  assign base_p1 = {{(CW + 1 - IW){1'b0}}, base_r} + 1'b1;
  assign sidx_p1 = {1'b0, sidx_r} + 1'b1;
  assign y_map   = {9'd0, seg_r.lvl} + {1'b0, prod_r};
  assign y_hi    = {9'd0, rmax_r, 8'd0};
  assign y_lo    = {9'd0, rmin_r, 8'd0};
  assign rd_seg  = seg_t'(rd_raw);

  // Configuration writes; they also drop the cached knot index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r <= COUNT_W'(1);
      ctl_pts_r <= 6'd1;
      smax_r    <= 16'd768;
      smin_r    <= 16'd0;
      dmin_r    <= 16'd0;
      dmax_r    <= 16'hFFFF;
      rmax_r    <= 16'd255;
      rmin_r    <= 16'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PIXEL_COUNT:    pix_cnt_r <= cfg_data;
        REG_CONTROL_POINTS: ctl_pts_r <= cfg_data[5:0];
        REG_SLOPE_MAX:      smax_r    <= cfg_data[15:0];
        REG_SLOPE_MIN:      smin_r    <= cfg_data[15:0];
        REG_DATA_MIN:       dmin_r    <= cfg_data[15:0];
        REG_DATA_MAX:       dmax_r    <= cfg_data[15:0];
        REG_RANGE_MAX:      rmax_r    <= cfg_data[15:0];
        REG_RANGE_MIN:      rmin_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Read address: search probe, found segment, or its successor.
  always_comb begin
    case (state_r)
      S_MRB:   rd_addr = probe;
      S_MCJ:   rd_addr = base_p1[IW-1:0];
      default: rd_addr = base_r;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign wr_en    = (state_r == S_AWR);

  always_comb begin
    state_nxt     = state_r;
    seg_cnt_nxt   = seg_cnt_r;
    sidx_nxt      = sidx_r;
    knot_nxt      = knot_r;
    last_pos_nxt  = last_pos_r;
    last_lvl_nxt  = last_lvl_r;
    idx_ok_nxt    = idx_ok_r & ~cfg_wr_en;
    idx_nxt       = idx_r;
    final_nxt     = final_r;
    v_nxt         = v_r;
    x1_nxt        = x1_r;
    tgt_nxt       = tgt_r;
    dx_nxt        = dx_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    s_nxt         = s_r;
    y_nxt         = y_r;
    base_nxt      = base_r;
    bit_nxt       = bit_r;
    probe_ok_nxt  = probe_ok_r;
    probe_nxt     = probe_r;
    seg_nxt       = seg_r;
    end_nxt       = end_r;
    prod_nxt      = prod_r;
    cov_nxt       = cov_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_nxt       = out_r;
    div_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          v_nxt = in_data.sample;
          if (in_data.command == CMD_LOAD) begin
            // Start of a load: reset the chain at the data minimum.
            if (sidx_r == '0) begin
              seg_cnt_nxt  = '0;
              knot_nxt     = 7'd1;
              last_pos_nxt = dmin_r;
              last_lvl_nxt = {rmin_r, 8'd0};
              idx_ok_nxt   = 1'b0;
            end
            state_nxt = S_LCHK;
          end else if (seg_cnt_r == '0) begin
            cov_nxt   = 1'b0;
            state_nxt = S_MOUT;
          end else begin
            base_nxt  = '0;
            bit_nxt   = BW'(IW - 1);
            state_nxt = S_MRB;
          end
        end
      end

      // Knot loop: every knot whose index is this sample is placed in turn.
      S_LCHK: begin
        if (knot_r > {1'b0, ctl_pts_r}) begin
          state_nxt = S_LEND;
        end else if (!idx_ok_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = 32'(knot_r) * 32'(n_eff) + 32'(ctl_pts_r);
          div_req.divisor  = 16'(np1);
          state_nxt        = S_LIDX;
        end else if (idx_r == sidx_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = 32'({rmax_r, 8'd0}) * 32'(knot_r);
          div_req.divisor  = 16'(np1);
          state_nxt        = S_LTGT;
        end else begin
          state_nxt = S_LEND;
        end
      end
      S_LIDX: begin
        if (div_rsp.done) begin
          idx_nxt    = div_rsp.quotient[COUNT_W-1:0] - 1'b1;
          idx_ok_nxt = 1'b1;
          state_nxt  = S_LCHK;
        end
      end
      S_LTGT: begin
        if (div_rsp.done) begin
          tgt_nxt   = div_rsp.quotient[LEVEL_W-1:0];
          x1_nxt    = v_r;
          final_nxt = 1'b0;
          state_nxt = S_ACHK;
        end
      end
      S_LEND: begin
        if (sidx_p1 >= {1'b0, n_eff}) begin
          // Close the chain at the data maximum.
          sidx_nxt  = '0;
          x1_nxt    = dmax_r;
          tgt_nxt   = {rmax_r, 8'd0};
          final_nxt = 1'b1;
          state_nxt = S_ACHK;
        end else begin
          sidx_nxt  = sidx_p1[COUNT_W-1:0];
          state_nxt = S_IDLE;
        end
      end

      // Add one knot unless it does not advance or the table is full: slope bounds, clipped level, segment write.
      S_ACHK: begin
        if (x1_r <= last_pos_r || seg_cnt_r >= CW'(MAX_SEGMENTS)) begin
          state_nxt = S_ARET;
        end else begin
          dx_nxt    = dx_c;
          lo_nxt    = 32'(smin_r) * 32'(dx_c);
          hi_nxt    = 32'(smax_r) * 32'(dx_c);
          state_nxt = S_ADEC;
        end
      end
      S_ADEC: begin
        if (diff_s < $signed({2'b00, lo_r})) begin
          s_nxt     = smin_r;
          y_nxt     = {9'd0, last_lvl_r} + {1'b0, lo_r};
          state_nxt = S_AWR;
        end else if (diff_s > $signed({2'b00, hi_r})) begin
          s_nxt     = smax_r;
          y_nxt     = {9'd0, last_lvl_r} + {1'b0, hi_r};
          state_nxt = S_AWR;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = diff_s[31:0];
          div_req.divisor  = dx_r;
          state_nxt        = S_ADIV;
        end
      end
      S_ADIV: begin
        if (div_rsp.done) begin
          s_nxt     = div_rsp.quotient[SLOPE_W-1:0];
          y_nxt     = {9'd0, tgt_r};
          state_nxt = S_AWR;
        end
      end
      S_AWR: begin
        seg_cnt_nxt  = seg_cnt_r + 1'b1;
        last_pos_nxt = x1_r;
        last_lvl_nxt = (y_r > {9'd0, LEVEL_SAT}) ? LEVEL_SAT : y_r[LEVEL_W-1:0];
        state_nxt    = S_ARET;
      end
      S_ARET: begin
        if (final_r) begin
          state_nxt = S_IDLE;
        end else begin
          knot_nxt   = knot_r + 1'b1;
          idx_ok_nxt = 1'b0;
          state_nxt  = S_LCHK;
        end
      end

      // Binary search for the last segment starting at or below the pixel.
      S_MRB: begin
        probe_nxt    = probe;
        probe_ok_nxt = ({1'b0, probe} < seg_cnt_r);
        state_nxt    = S_MCB;
      end
      S_MCB: begin
        if (probe_ok_r && rd_seg.pos <= v_r) begin
          base_nxt = probe_r;
        end
        if (bit_r == '0) begin
          state_nxt = S_MRJ;
        end else begin
          bit_nxt   = bit_r - 1'b1;
          state_nxt = S_MRB;
        end
      end
      S_MRJ: begin
        state_nxt = S_MCJ;
      end
      S_MCJ: begin
        seg_nxt = rd_seg;
        if (base_p1 < {1'b0, seg_cnt_r}) begin
          state_nxt = S_MCE;
        end else begin
          end_nxt   = last_pos_r;
          state_nxt = S_MMUL;
        end
      end
      S_MCE: begin
        end_nxt   = rd_seg.pos;
        state_nxt = S_MMUL;
      end
      S_MMUL: begin
        if (seg_r.pos <= v_r && v_r <= end_r) begin
          prod_nxt  = 32'(seg_r.slope) * 32'(v_r - seg_r.pos);
          cov_nxt   = 1'b1;
          state_nxt = S_MADD;
        end else begin
          cov_nxt   = 1'b0;
          state_nxt = S_MOUT;
        end
      end
      S_MADD: begin
        // Clamp to the top of the range first, then the bottom.
        y_nxt = y_map;
        if (y_nxt > y_hi) begin
          y_nxt = y_hi;
        end
        if (y_nxt < y_lo) begin
          y_nxt = y_lo;
        end
        state_nxt = S_MOUT;
      end
      S_MOUT: begin
        // Hold until the result register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.covered      = cov_r;
          out_nxt.mapped_value = cov_r ? y_r[23:8] : '0;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seg_cnt_r   <= '0;
      sidx_r      <= '0;
      knot_r      <= 7'd1;
      last_pos_r  <= '0;
      last_lvl_r  <= '0;
      idx_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_cnt_r   <= seg_cnt_nxt;
      sidx_r      <= sidx_nxt;
      knot_r      <= knot_nxt;
      last_pos_r  <= last_pos_nxt;
      last_lvl_r  <= last_lvl_nxt;
      idx_ok_r    <= idx_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    final_r    <= final_nxt;
    v_r        <= v_nxt;
    x1_r       <= x1_nxt;
    tgt_r      <= tgt_nxt;
    dx_r       <= dx_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    s_r        <= s_nxt;
    y_r        <= y_nxt;
    base_r     <= base_nxt;
    bit_r      <= bit_nxt;
    probe_ok_r <= probe_ok_nxt;
    probe_r    <= probe_nxt;
    seg_r      <= seg_nxt;
    end_r      <= end_nxt;
    prod_r     <= prod_nxt;
    cov_r      <= cov_nxt;
    out_r      <= out_nxt;
  end

  // Segment table; writes happen only during loads, and read data is used only during maps.
  pae_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (seg_cnt_r[IW-1:0]),
    .wr_data ({last_pos_r, last_lvl_r, s_r}),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  pae_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_seg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seg_cnt_r <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond table depth");

  a_wr_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> seg_cnt_r < CW'(MAX_SEGMENTS))
    else $error("segment write with full table");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && out_stall)) |-> state_r == S_MOUT)
    else $error("result loaded outside output state");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
`endif

endmodule

@@ bench/tb_piecewise_affine_equalizer.sv @@
// Self-checking bench for the piecewise affine equalizer: directed and random load/map beats.
module tb_piecewise_affine_equalizer;
  timeunit 1ns;
  timeprecision 1ps;
  import pae_pkg::*;

  localparam int MAX_SEG = 64;
  localparam longint LVL_CAP = 64'hFF_FFFF;

  // Predictor of the knot table plus a queue of expected map results.
  class equalizer_scoreboard;
    longint pix_cnt, ctl_pts, s_max, s_min, d_min, d_max, r_max, r_min;
    logic [15:0] kpos[MAX_SEG];
    logic [23:0] klvl[MAX_SEG];
    logic [15:0] kslope[MAX_SEG];
    longint seg_cnt, sort_idx, next_knot, last_pos, last_lvl;
    out_t expected_q[$];
    int errors, maps_checked, covered_seen;

    function new();
      pix_cnt = 1; ctl_pts = 1; s_max = 768; s_min = 0;
      d_min = 0; d_max = 65535; r_max = 255; r_min = 0;
      seg_cnt = 0; sort_idx = 0; next_knot = 1; last_pos = 0; last_lvl = 0;
      errors = 0; maps_checked = 0; covered_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_PIXEL_COUNT:    pix_cnt = v;
        REG_CONTROL_POINTS: ctl_pts = v[5:0];
        REG_SLOPE_MAX:      s_max = v[15:0];
        REG_SLOPE_MIN:      s_min = v[15:0];
        REG_DATA_MIN:       d_min = v[15:0];
        REG_DATA_MAX:       d_max = v[15:0];
        REG_RANGE_MAX:      r_max = v[15:0];
        default:            r_min = v[15:0];
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void place_knot(longint x1, longint target);
      longint dx, diff, y, s;
      if (x1 <= last_pos || seg_cnt >= MAX_SEG) return;
      dx = x1 - last_pos;
      diff = target - last_lvl;
      if (diff < s_min * dx) begin
        s = s_min;
        y = last_lvl + s * dx;
      end else if (diff > s_max * dx) begin
        s = s_max;
        y = last_lvl + s * dx;
      end else begin
        s = diff / dx;
        y = target;
      end
      if (y > LVL_CAP) y = LVL_CAP;
      kpos[seg_cnt] = last_pos[15:0];
      klvl[seg_cnt] = last_lvl[23:0];
      kslope[seg_cnt] = s[15:0];
      seg_cnt++;
      last_pos = x1;
      last_lvl = y;
    endfunction

    function void note_input(in_t d);
      longint n, np1, idx, v, y, x0, x1;
      out_t r;
      v = d.sample;
      if (d.command == CMD_LOAD) begin
        n = (pix_cnt != 0) ? pix_cnt : 1;
        np1 = ctl_pts + 1;
        // first sorted beat of a load restarts the chain
        if (sort_idx == 0) begin
          seg_cnt = 0; next_knot = 1; last_pos = d_min; last_lvl = r_min << 8;
        end
        while (next_knot <= ctl_pts) begin
          idx = (next_knot * n + ctl_pts) / np1 - 1;
          if (idx != sort_idx) break;
          place_knot(v, (r_max * 256 * next_knot) / np1);
          next_knot++;
        end
        sort_idx = (sort_idx + 1) & 64'hFF_FFFF;
        if (sort_idx >= n) begin
          place_knot(d_max, r_max << 8);
          sort_idx = 0;
        end
        return;
      end
      r = '0;
      // last segment that holds the pixel wins
      for (longint i = seg_cnt; i > 0; i--) begin
        x0 = kpos[i-1];
        x1 = (i == seg_cnt) ? last_pos : longint'(kpos[i]);
        if (x0 <= v && v <= x1) begin
          y = longint'(klvl[i-1]) + longint'(kslope[i-1]) * (v - x0);
          if (y > (r_max << 8)) y = r_max << 8;
          if (y < (r_min << 8)) y = r_min << 8;
          r.mapped_value = y[23:8];
          r.covered = 1'b1;
          break;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat mapped_value=%0d covered=%0b",
               got.mapped_value, got.covered);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      maps_checked++;
      if (exp_r.covered) covered_seen++;
      if (got.mapped_value !== exp_r.mapped_value) begin
        $error("mapped_value: expected %0d, actual %0d", exp_r.mapped_value, got.mapped_value);
        errors++;
      end
      if (got.covered !== exp_r.covered) begin
        $error("covered: expected %0b, actual %0b", exp_r.covered, got.covered);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_t in_data;
  out_t out_data;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  equalizer_scoreboard sb = new();
  bit quiet;          // phases with no idling on either side
  int phases_run;

  piecewise_affine_equalizer #(.MAX_SEGMENTS(MAX_SEG)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hold a beat until it is taken. Valid drops only when a gap follows, so a
  // back-to-back beat never sees a low/high pair in one step. Stall is read at
  // the falling edge, where it has settled for the coming rising edge.
  task automatic send_beat(logic cmd, logic [15:0] val);
    int gap;
    bit took;
    in_t d;
    gap = quiet ? 0 : int'($urandom_range(0, 9));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    d.command = cmd;
    d.sample = val;
    in_valid <= 1'b1;
    in_data <= d;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    sb.note_input(d);
  endtask

  // Pause the sender until every result is back, then let any load work finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic configure(int pc, int cp, int smax, int smin, int dmin, int dmax,
                           int rmax, int rmin);
    write_reg(REG_PIXEL_COUNT, CFG_W'(pc));
    write_reg(REG_CONTROL_POINTS, CFG_W'(cp));
    write_reg(REG_SLOPE_MAX, CFG_W'(smax));
    write_reg(REG_SLOPE_MIN, CFG_W'(smin));
    write_reg(REG_DATA_MIN, CFG_W'(dmin));
    write_reg(REG_DATA_MAX, CFG_W'(dmax));
    write_reg(REG_RANGE_MAX, CFG_W'(rmax));
    write_reg(REG_RANGE_MIN, CFG_W'(rmin));
    cfg_wr_en <= 1'b0;
    phases_run++;
  endtask

  // One sorted load of n samples in [lo,hi] with pixels mapped in between,
  // then a run of pixels on the chain it leaves.
  task automatic load_and_map(int n, int lo, int hi, int map_pct, int tail, ref int cnt);
    int vals[$];
    for (int i = 0; i < n; i++) vals.push_back($urandom_range(lo, hi));
    vals.sort();
    foreach (vals[i]) begin
      if ($urandom_range(0, 99) < map_pct) begin
        send_beat(CMD_MAP, 16'($urandom_range(0, 65535)));
        cnt++;
      end
      send_beat(CMD_LOAD, 16'(vals[i]));
      cnt++;
    end
    for (int i = 0; i < tail; i++) begin
      send_beat(CMD_MAP, 16'(($urandom_range(0, 1) != 0) ? $urandom_range(lo, hi)
                                                          : $urandom_range(0, 65535)));
      cnt++;
    end
  endtask

  // Result side: stall a random while before each beat, then take it.
  initial begin
    int n;
    bit got;
    out_t d;
    out_stall = 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = quiet ? 0 : int'($urandom_range(0, 9));
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        got = out_valid;
        d = out_data;
        @(posedge clk);
      end while (!got);
      sb.check_result(d);
    end
  end

  initial begin
    int cnt, lo, hi, a, b;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    phases_run = 0;
    cnt = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no segments yet, so every pixel is uncovered.
    send_beat(CMD_MAP, 16'h0000);
    send_beat(CMD_MAP, 16'hFFFF);
    // Reset defaults: one-sample load builds a knot plus the final knot.
    send_beat(CMD_LOAD, 16'h8000);
    send_beat(CMD_MAP, 16'h0000);
    send_beat(CMD_MAP, 16'h8000);
    send_beat(CMD_MAP, 16'h9C40);
    send_beat(CMD_MAP, 16'hFFFF);
    // Knot on data minimum is dropped; only the final knot stays.
    send_beat(CMD_LOAD, 16'h0000);
    send_beat(CMD_MAP, 16'h1234);
    drain();

    // Zero pixel count, crossed slope bounds, saturating levels.
    configure(0, 63, 0, 65535, 0, 65535, 65535, 0);
    send_beat(CMD_LOAD, 16'hFFFF);
    send_beat(CMD_LOAD, 16'h0001);
    send_beat(CMD_MAP, 16'h0000);
    send_beat(CMD_MAP, 16'h0001);
    send_beat(CMD_MAP, 16'hFFFF);
    drain();

    // Many knots sharing samples, crossed output range.
    configure(8, 63, 65535, 0, 100, 60000, 50, 200);
    load_and_map(8, 100, 60000, 0, 4, cnt);
    drain();

    // Full table: 63 distinct knots plus the final one.
    configure(64, 63, 65535, 0, 0, 65535, 65535, 0);
    for (int i = 1; i <= 64; i++) send_beat(CMD_LOAD, 16'(i * 1000));
    for (int i = 0; i < 4; i++) send_beat(CMD_MAP, 16'($urandom_range(0, 65535)));
    drain();

    // Random phases.
    cnt = 0;
    while (cnt < 400) begin
      quiet = ($urandom_range(0, 4) == 0);
      a = $urandom_range(0, 65535);
      b = $urandom_range(0, 65535);
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if ($urandom_range(0, 5) == 0) begin
        lo = 0;
        hi = 65535;
      end
      configure($urandom_range(1, 40), $urandom_range(1, 63),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2048),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 64),
                ($urandom_range(0, 7) == 0) ? hi : lo,
                ($urandom_range(0, 7) == 0) ? lo : hi,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(128, 1023),
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 64));
      // mostly well-formed loads; now and then a stray pixel or a cut load
      if ($urandom_range(0, 7) == 0)
        load_and_map($urandom_range(1, 10), lo, hi, 40, 10, cnt);
      else
        load_and_map(int'(sb.pix_cnt), lo, hi, 25, $urandom_range(5, 25), cnt);
      drain();
    end
    quiet = 1'b0;

    // Largest pixel count: the load never ends, so it places no knot.
    configure(16777215, 63, 768, 0, 0, 65535, 255, 0);
    load_and_map(5, 0, 65535, 50, 5, cnt);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("run covered %0d config phases, %0d map results (%0d covered)",
             phases_run, sb.maps_checked, sb.covered_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("status: fail");
    $finish;
  end
endmodule
